### rtl/core/whtqp_pkg.sv
package whtqp_pkg;

    localparam int unsigned TableSlotsDefault = 8191;
    localparam int unsigned MaxWordLenDefault = 17;
    localparam logic [15:0] MaxProbesReset    = 16'd12967;
    localparam logic [12:0] CountMax          = 13'd8191;

    localparam int unsigned FuncWidth  = 1;
    localparam int unsigned CharWidth  = 8;
    localparam int unsigned SlotWidth  = 13;
    localparam int unsigned StatWidth  = 2;
    localparam int unsigned CountWidth = 13;
    localparam int unsigned ProbeWidth = 16;

    localparam logic [0:0] FuncInsert = 1'b0;
    localparam logic [0:0] FuncLookup = 1'b1;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatNoSlot  = 2'd1;
    localparam logic [1:0] StatTooLong = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_COLLECT,
        S_MUL1,
        S_MUL2,
        S_MOD,
        S_QUOT,
        S_REM,
        S_FIX,
        S_PROBE,
        S_WAIT,
        S_CHECK,
        S_WRITE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [FuncWidth-1:0]  func;
        logic [CharWidth-1:0]  char_code;
        logic                  last_char;
    } t_req;

    typedef struct packed {
        logic                  found;
        logic [SlotWidth-1:0]  slot_index;
        logic [StatWidth-1:0]  status;
        logic [CountWidth-1:0] entry_count;
    } t_rsp;

endpackage

### rtl/core/whtqp_if.sv
interface whtqp_req_if;
    import whtqp_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface whtqp_rsp_if;
    import whtqp_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/whtqp_slot_mem.sv
module whtqp_slot_mem #(
    parameter int unsigned Depth = 8191,
    parameter int unsigned Width = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] mem [Depth];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule

### rtl/core/word_hash_table_quadratic_probe_unit.sv
// Channel  | Dir | Payload
// i_req    | in  | func, char_code, last_char (one character per request)
// o_rsp    | out | found, slot_index, status, entry_count (one per word)
// A final character runs hash and reduction steps MUL1, MUL2, MOD, QUOT, REM, FIX,
// then each probe position passes PROBE, WAIT, CHECK (address, memory read, compare);
// running out of positions ends the search, an insert adds a WRITE state, and RESULT
// loads the response; a word over MaxWordLen goes straight to RESULT. After reset the
// slot memory is cleared one slot a cycle; no requests are taken meanwhile. A pending
// response holds until o_rsp.ready is high, and no request is taken while it waits.
module word_hash_table_quadratic_probe_unit #(
    parameter int unsigned TableSlots = whtqp_pkg::TableSlotsDefault,
    parameter int unsigned MaxWordLen = whtqp_pkg::MaxWordLenDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [whtqp_pkg::ProbeWidth-1:0] i_cfg_wdata,
    whtqp_req_if.sink                       i_req,
    whtqp_rsp_if.source                     o_rsp
);
    import whtqp_pkg::*;

    localparam int unsigned AW  = $clog2(TableSlots);
    localparam int unsigned LW  = $clog2(MaxWordLen + 1);
    localparam int unsigned MW  = (MaxWordLen + 1) * CharWidth;
    localparam logic [AW-1:0] LastSlot = AW'(TableSlots - 1);
    localparam logic [LW-1:0] MaxLen   = LW'(MaxWordLen);
    localparam logic [AW:0]   Slots    = (AW+1)'(TableSlots);
    localparam logic [31:0]   SlotsWord = 32'(TableSlots);
    localparam logic [31:0]   Recip    = 32'((64'd1 << 32) / 64'(TableSlots));
    localparam logic [AW:0]   WrapRem  = (AW+1)'((64'd1 << 32) % 64'(TableSlots));
    localparam logic [AW:0]   WrapAdd  = Slots - WrapRem;

    t_state r_state, n_state;
    logic [ProbeWidth-1:0] r_max_probes;
    logic [CharWidth-1:0]  r_buf [MaxWordLen];
    logic [31:0]           r_sum, r_n, r_mul, r_q;
    logic [CharWidth-1:0]  r_first, r_lastc;
    logic [LW-1:0]         r_cnt;
    logic                  r_func, r_too_long;
    logic [CountWidth-1:0] r_words;
    logic [AW-1:0]         r_clr;
    logic [AW-1:0]         r_addr;
    logic [AW:0]           r_rem;
    logic [AW:0]           r_pos;
    logic [AW:0]           r_step;
    logic [32:0]           r_nsq;
    logic [ProbeWidth+1:0] r_odd;
    logic [ProbeWidth-1:0] r_probe;
    logic                  r_rsp_v;
    t_rsp                  r_rsp;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [MW-1:0]         mem_wdata, mem_rdata;
    logic [MW-1:0]         word_img;
    logic [63:0]           quot_prod;
    logic [AW:0]           eff_addr;
    logic                  accept, slot_empty, slot_match;

    whtqp_slot_mem #(.Depth(TableSlots), .Width(MW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready = (r_state == S_COLLECT) && !r_rsp_v;
    assign accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_rsp_v;
    assign o_rsp.data  = r_rsp;

    // pack word image: length byte in the low byte, characters above
    always_comb begin
        word_img = '0;
        word_img[CharWidth-1:0] = CharWidth'(r_cnt);
        for (int k = 0; k < MaxWordLen; k++) begin
            if (LW'(k) < r_cnt) begin
                word_img[(k+1)*CharWidth +: CharWidth] = r_buf[k];
            end
        end
    end

    assign slot_empty = (mem_rdata[CharWidth-1:0] == '0);
    assign slot_match = (mem_rdata == word_img);
    assign mem_raddr  = r_addr;
    assign mem_we     = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign mem_waddr  = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign mem_wdata  = (r_state == S_CLEAR) ? '0 : word_img;

    // quotient estimate by reciprocal multiplication
    assign quot_prod = {32'd0, r_n} * {32'd0, Recip};

    // once n + i*i has passed 2^32 the 32-bit sum wraps: drop 2^32 mod TableSlots
    assign eff_addr = !r_nsq[32] ? r_pos
                    : (r_pos >= WrapRem) ? r_pos - WrapRem : r_pos + WrapAdd;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:   if (r_clr == LastSlot) n_state = S_COLLECT;
            S_COLLECT: begin
                if (accept && i_req.data.last_char) begin
                    if (r_too_long || r_cnt >= MaxLen) n_state = S_RESULT;
                    else n_state = S_MUL1;
                end
            end
            S_MUL1:    n_state = S_MUL2;
            S_MUL2:    n_state = S_MOD;
            S_MOD:     n_state = S_QUOT;
            S_QUOT:    n_state = S_REM;
            S_REM:     n_state = S_FIX;
            S_FIX:     n_state = S_PROBE;
            S_PROBE:   n_state = (r_probe >= r_max_probes) ? S_RESULT : S_WAIT;
            S_WAIT:    n_state = S_CHECK;
            S_CHECK: begin
                if (r_func == FuncInsert) begin
                    n_state = slot_empty ? S_WRITE : S_PROBE;
                end else begin
                    n_state = (slot_empty || slot_match) ? S_RESULT : S_PROBE;
                end
            end
            S_WRITE:   n_state = S_RESULT;
            S_RESULT:  n_state = S_COLLECT;
            default:   n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_max_probes <= MaxProbesReset;
        else if (i_cfg_we) r_max_probes <= i_cfg_wdata;
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                r_clr <= '0;
        else if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
    end

    // collect characters and accumulate hash sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_too_long <= 1'b0; r_sum <= '0;
            r_first <= '0; r_func <= 1'b0;
        end else if (accept) begin
            logic [31:0] base;
            base = (r_cnt == '0 && !r_too_long) ? 32'd0 : r_sum;
            if (r_cnt == '0 && !r_too_long) begin
                r_func  <= i_req.data.func;
                r_first <= i_req.data.char_code;
            end
            r_sum <= base;
            if (r_too_long || r_cnt >= MaxLen) begin
                r_too_long <= 1'b1;
            end else begin
                r_buf[r_cnt[LW-1:0] < MaxLen ? r_cnt : '0] <= i_req.data.char_code;
                r_cnt <= r_cnt + LW'(1);
                if (!i_req.data.last_char) begin
                    r_sum <= base + 32'(r_cnt + LW'(1))
                           * ({24'd0, i_req.data.char_code} - 32'd64);
                end
            end
            r_lastc <= i_req.data.char_code;
        end else if (r_state == S_RESULT) begin
            r_cnt <= '0; r_too_long <= 1'b0;
        end
    end

    // hash product, reduction, quadratic probe stepping
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL1: r_mul <= 32'(r_first) + 32'(r_cnt) * ({24'd0, r_lastc} - 32'd64);
            S_MUL2: r_n   <= r_sum * r_mul;
            S_MOD: begin
                r_n     <= r_n * 32'(r_cnt);
                r_step  <= (AW+1)'(1);
                r_odd   <= (ProbeWidth+2)'(1);
                r_probe <= '0;
            end
            S_QUOT: r_q   <= quot_prod[63:32];
            S_REM:  r_rem <= (AW+1)'(r_n - r_q * SlotsWord);
            S_FIX: begin
                // estimate is at most one short: one subtract finishes the reduction
                r_pos <= (r_rem >= Slots) ? r_rem - Slots : r_rem;
                r_nsq <= {1'b0, r_n};
            end
            S_PROBE: r_addr <= eff_addr[AW-1:0];
            S_CHECK: begin
                // next offset: (i+1)^2 = i^2 + (2i+1), all mod TableSlots
                r_pos  <= ((r_pos + r_step) >= Slots)
                        ? r_pos + r_step - Slots : r_pos + r_step;
                r_step <= ((r_step + (AW+1)'(2)) >= Slots)
                        ? r_step + (AW+1)'(2) - Slots : r_step + (AW+1)'(2);
                r_nsq  <= r_nsq + 33'(r_odd);
                r_odd  <= r_odd + (ProbeWidth+2)'(2);
                r_probe <= r_probe + ProbeWidth'(1);
            end
            default: ;
        endcase
    end

    // entry counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_words <= '0;
        else if (r_state == S_WRITE && r_words != CountMax) r_words <= r_words + 13'd1;
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_v <= 1'b0;
        end else begin
            if (o_rsp.ready) r_rsp_v <= 1'b0;
            if (r_state == S_RESULT) begin
                r_rsp_v <= 1'b1;
                r_rsp.entry_count <= r_words;
            end
            if (r_state == S_COLLECT && accept && i_req.data.last_char
                && (r_too_long || r_cnt >= MaxLen)) begin
                r_rsp.found <= 1'b0; r_rsp.slot_index <= '0; r_rsp.status <= StatTooLong;
            end
            if (r_state == S_PROBE && r_probe >= r_max_probes) begin
                r_rsp.found <= 1'b0; r_rsp.slot_index <= '0; r_rsp.status <= StatNoSlot;
            end
            if (r_state == S_CHECK) begin
                if (r_func == FuncInsert && slot_empty) begin
                    r_rsp.found <= 1'b1; r_rsp.status <= StatOk;
                    r_rsp.slot_index <= SlotWidth'(r_addr);
                end else if (r_func == FuncLookup && slot_empty) begin
                    r_rsp.found <= 1'b0; r_rsp.slot_index <= '0; r_rsp.status <= StatOk;
                end else if (r_func == FuncLookup && slot_match) begin
                    r_rsp.found <= 1'b1; r_rsp.status <= StatOk;
                    r_rsp.slot_index <= SlotWidth'(r_addr);
                end
            end
        end
    end
endmodule
